@@ src/stepper_phase_sequencer_ramp_unit_macros.svh @@
// Assertion macros shared by the stepper phase sequencer ramp unit.
`ifndef STEPPER_PHASE_SEQUENCER_RAMP_UNIT_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_RAMP_UNIT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define PSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/psr_pkg.sv @@
// Types, constants and helpers for the stepper phase sequencer ramp unit.
`timescale 1ns / 1ps
package psr_pkg;

  localparam int PHASES        = 9;
  localparam int TABLE_ENTRIES = 9;
  localparam int PAT_W         = 4;
  localparam int TABLE_W       = TABLE_ENTRIES * PAT_W;
  localparam int PHASE_W       = 4;
  localparam int WAIT_W        = 8;
  localparam int RAMP_W        = 16;
  localparam int CFG_DATA_W    = TABLE_W;
  localparam int CFG_IDX_W     = 3;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASES - 1);

  localparam logic [WAIT_W-1:0]  START_WAIT_RST  = 8'd60;
  localparam logic [WAIT_W-1:0]  MIN_WAIT_RST    = 8'd4;
  localparam logic [RAMP_W-1:0]  RAMP_TICKS_RST  = 16'd1000;
  localparam logic [TABLE_W-1:0] PHASE_TABLE_RST = 36'h4_4422_2111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_WAIT  = 3'd0,
    CFG_MIN_WAIT    = 3'd1,
    CFG_RAMP_TICKS  = 3'd2,
    CFG_PHASE_TABLE = 3'd3
  } cfg_index_t;

  typedef struct packed {
    logic [WAIT_W-1:0]  start_wait;
    logic [WAIT_W-1:0]  min_wait;
    logic [RAMP_W-1:0]  ramp_ticks;
    logic [TABLE_W-1:0] phase_table;
  } psr_cfg_t;

  typedef struct packed {
    logic [PAT_W-1:0]   drive_n;
    logic [PHASE_W-1:0] phase;
    logic [WAIT_W-1:0]  step_period;
    logic               stepped;
  } psr_result_t;

  // Coil pattern at a phase index; entries past the table read as zero.
  function automatic logic [PAT_W-1:0] pattern_at(input logic [TABLE_W-1:0] tbl,
                                                  input logic [PHASE_W-1:0] idx);
    logic [PAT_W-1:0] ent [2**PHASE_W];
    for (int i = 0; i < 2**PHASE_W; i++) begin
      if (i < TABLE_ENTRIES) begin
        ent[i] = tbl[i*PAT_W +: PAT_W];
      end else begin
        ent[i] = '0;
      end
    end
    return ent[idx];
  endfunction

endpackage

@@ src/psr_cfg_regs.sv @@
// Configuration register file of the stepper phase sequencer ramp unit.
`timescale 1ns / 1ps
module psr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output psr_pkg::psr_cfg_t              cfg
);
  import psr_pkg::*;

  psr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_wait  <= START_WAIT_RST;
      cfg_r.min_wait    <= MIN_WAIT_RST;
      cfg_r.ramp_ticks  <= RAMP_TICKS_RST;
      cfg_r.phase_table <= PHASE_TABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_WAIT:  cfg_r.start_wait  <= cfg_wdata[WAIT_W-1:0];
        CFG_MIN_WAIT:    cfg_r.min_wait    <= cfg_wdata[WAIT_W-1:0];
        CFG_RAMP_TICKS:  cfg_r.ramp_ticks  <= cfg_wdata[RAMP_W-1:0];
        CFG_PHASE_TABLE: cfg_r.phase_table <= cfg_wdata[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/psr_step.sv @@
// Sequencer state and per-tick step logic with the speed ramp.
`timescale 1ns / 1ps
`include "stepper_phase_sequencer_ramp_unit_macros.svh"
module psr_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_go,
  input  logic                 tick,
  input  psr_pkg::psr_cfg_t    cfg,
  output psr_pkg::psr_result_t res
);
  import psr_pkg::*;

  logic               started_r, started_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [WAIT_W-1:0]  wait_count_r, wait_count_nxt;
  logic [WAIT_W-1:0]  period_r, period_nxt;
  logic [RAMP_W-1:0]  ramp_count_r, ramp_count_nxt;
  logic               stepped;
  logic               step_due;
  logic               ramp_due;

  assign step_due = (wait_count_r >= period_r);
  assign ramp_due = (ramp_count_r >= cfg.ramp_ticks) && (period_r > cfg.min_wait);

  always_comb begin
    started_nxt    = started_r;
    phase_nxt      = phase_r;
    wait_count_nxt = wait_count_r;
    period_nxt     = period_r;
    ramp_count_nxt = ramp_count_r;
    stepped        = 1'b0;
    if (step_go && tick) begin
      if (!started_r) begin
        phase_nxt   = '0;
        period_nxt  = cfg.start_wait;
        started_nxt = 1'b1;
      end else begin
        if (step_due) begin
          phase_nxt      = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
          wait_count_nxt = '0;
          stepped        = 1'b1;
        end else begin
          wait_count_nxt = wait_count_r + 1'b1;
        end
        if (ramp_due) begin
          ramp_count_nxt = '0;
          period_nxt     = period_r - 1'b1;
        end else begin
          ramp_count_nxt = ramp_count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      phase_r      <= '0;
      wait_count_r <= '0;
      period_r     <= START_WAIT_RST;
      ramp_count_r <= '0;
    end else begin
      started_r    <= started_nxt;
      phase_r      <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      period_r     <= period_nxt;
      ramp_count_r <= ramp_count_nxt;
    end
  end

  assign res.drive_n     = ~pattern_at(cfg.phase_table, phase_nxt);
  assign res.phase       = phase_nxt;
  assign res.step_period = period_nxt;
  assign res.stepped     = stepped;

  `PSR_ASSERT(a_phase_in_range, phase_r <= PHASE_LAST, "phase index out of range")
  `PSR_ASSERT(a_idle_counters, !started_r |-> (wait_count_r == '0 && ramp_count_r == '0),
              "counters moved before the first tick")
  `PSR_ASSERT(a_step_clears_wait, (step_go && tick && started_r && step_due) |=>
              (wait_count_r == '0 && phase_r != $past(phase_r)),
              "step did not clear the wait counter and advance the phase")
  `PSR_ASSERT(a_ramp_period, (step_go && tick && started_r && ramp_due) |=>
              (period_r == $past(period_r) - 1'b1 && ramp_count_r == '0),
              "ramp did not shorten the period")

endmodule

@@ src/stepper_phase_sequencer_ramp_unit.sv @@
// Top level of the stepper phase sequencer with linear speed ramp.
`timescale 1ns / 1ps
// Path: an accepted tick goes into the input register, then into the result
// register, from which its result can transfer.
// Throughput: one tick per cycle unless the result side stalls; the step and ramp
// update is one short compare/increment pass between the two registers.
// Reset (rst_n low, synchronous): pipeline empty, sequencer not started,
// period back to 60, configuration registers back to their defaults.
module stepper_phase_sequencer_ramp_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // tick channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tick,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psr_pkg::PAT_W-1:0]      out_drive_n,
  output logic [psr_pkg::PHASE_W-1:0]    out_phase,
  output logic [psr_pkg::WAIT_W-1:0]     out_step_period,
  output logic                           out_stepped
);
  import psr_pkg::*;

  psr_cfg_t    cfg;
  psr_result_t res;
  psr_result_t res_r;

  logic in_valid_r;
  logic in_tick_r;
  logic out_valid_r;
  logic advance;
  logic step_go;

  // The result register can take a new entry when it is empty or its
  // current entry is being transferred this cycle.
  assign advance = !out_valid_r || !out_stall;
  // Process the held tick as it moves into the result register.
  assign step_go = in_valid_r && advance;
  // Hold the input side only when a tick is parked and cannot move on.
  assign in_stall = in_valid_r && !advance;

  psr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psr_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_go (step_go),
    .tick    (in_tick_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register: load a new transfer whenever the parked tick moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_tick_r <= in_tick;
    end
  end

  // Result register: capture the step outcome, drop it once transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_n     = res_r.drive_n;
  assign out_phase       = res_r.phase;
  assign out_step_period = res_r.step_period;
  assign out_stepped     = res_r.stepped;

endmodule

@@ test/stepper_phase_sequencer_ramp_unit_test.sv @@
// Self-checking testbench for the stepper phase sequencer ramp unit.
`timescale 1ns / 1ps
module stepper_phase_sequencer_ramp_unit_test;
  import psr_pkg::*;

  // Stop the run if it hangs.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  cfg_index_t            cfg_index = CFG_START_WAIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_tick  = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PAT_W-1:0]   out_drive_n;
  logic [PHASE_W-1:0] out_phase;
  logic [WAIT_W-1:0]  out_step_period;
  logic               out_stepped;

  // Random idling on both channels; hold_left forces a long receiver stall.
  bit idle_on   = 1'b1;
  int hold_left = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Expected coil results, oldest first, one per accepted tick.
  psr_result_t pending_coil_results[$];

  // Shadow copy of the configuration registers and of the sequencer state.
  psr_cfg_t           shadow = {START_WAIT_RST, MIN_WAIT_RST, RAMP_TICKS_RST, PHASE_TABLE_RST};
  logic               seq_started = 1'b0;
  logic [PHASE_W-1:0] phase_idx   = '0;
  logic [WAIT_W-1:0]  wait_cnt    = '0;
  logic [WAIT_W-1:0]  period      = START_WAIT_RST;
  logic [RAMP_W-1:0]  ramp_cnt    = '0;

  stepper_phase_sequencer_ramp_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tick         (in_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_n     (out_drive_n),
    .out_phase       (out_phase),
    .out_step_period (out_step_period),
    .out_stepped     (out_stepped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow sequencer by one tick and return the coil result it drives.
  function automatic psr_result_t predict_coil_step(input logic tick);
    psr_result_t res;
    res.stepped = 1'b0;
    if (tick) begin
      if (!seq_started) begin
        // First tick: load the period, stay on phase 0, leave the ramp alone.
        phase_idx   = '0;
        period      = shadow.start_wait;
        seq_started = 1'b1;
      end else begin
        // Step once the wait counter has caught up with the period.
        if (wait_cnt >= period) begin
          phase_idx   = PHASE_W'((phase_idx + 1) % PHASES);
          wait_cnt    = '0;
          res.stepped = 1'b1;
        end else begin
          wait_cnt = wait_cnt + 1'b1;
        end
        // Shorten the period on ramp expiry unless it sits at the floor.
        if (ramp_cnt >= shadow.ramp_ticks && period > shadow.min_wait) begin
          ramp_cnt = '0;
          period   = period - 1'b1;
        end else begin
          ramp_cnt = ramp_cnt + 1'b1;
        end
      end
    end
    // Entries beyond the table read as an all-off pattern.
    res.drive_n     = (phase_idx < TABLE_ENTRIES) ? ~shadow.phase_table[PAT_W*phase_idx +: PAT_W]
                                                  : {PAT_W{1'b1}};
    res.phase       = phase_idx;
    res.step_period = period;
    return res;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [TABLE_W-1:0] random_table();
    return TABLE_W'({$urandom(), $urandom()});
  endfunction

  // Offer one tick, hold it until the transfer, then log its expected result.
  task automatic send_tick(input logic tick);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    do @(posedge clk); while (in_stall);
    pending_coil_results.push_back(predict_coil_step(tick));
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_coil_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_START_WAIT:  shadow.start_wait  = value[WAIT_W-1:0];
      CFG_MIN_WAIT:    shadow.min_wait    = value[WAIT_W-1:0];
      CFG_RAMP_TICKS:  shadow.ramp_ticks  = value[RAMP_W-1:0];
      CFG_PHASE_TABLE: shadow.phase_table = value[TABLE_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram all registers while the block is idle.
  task automatic configure(input logic [WAIT_W-1:0] start_wait, input logic [WAIT_W-1:0] min_wait,
                           input logic [RAMP_W-1:0] ramp_ticks,
                           input logic [TABLE_W-1:0] coil_table);
    drain_results();
    write_reg(CFG_START_WAIT, CFG_DATA_W'(start_wait));
    write_reg(CFG_MIN_WAIT, CFG_DATA_W'(min_wait));
    write_reg(CFG_RAMP_TICKS, CFG_DATA_W'(ramp_ticks));
    write_reg(CFG_PHASE_TABLE, CFG_DATA_W'(coil_table));
    cfg_we <= 1'b0;
  endtask

  // Random ticks, mostly high, with idling switched on and off in stretches.
  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_tick($urandom_range(0, 7) != 0);
    end
    idle_on = 1'b1;
  endtask

  // Idle ticks before start report the reset period; the first tick loads
  // the longest start wait and must not step or ramp.
  task automatic test_first_tick();
    configure(8'hFF, 8'h00, 16'h0000, '0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // All-on and all-off tables, a late start wait write that must be ignored,
  // and the highest floor and ramp length, which freeze the period.
  task automatic test_register_extremes();
    configure(8'h00, 8'h00, 16'h0000, {TABLE_W{1'b1}});
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    configure(8'h80, 8'hFF, 16'hFFFF, '0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Ramp the period down onto a high floor, then onto a lower one.
  task automatic test_ramp_to_floor();
    configure(WAIT_W'($urandom_range(0, 255)), 8'd200, 16'd3, random_table());
    run_ticks(300);
    configure(WAIT_W'($urandom_range(0, 255)), 8'd20, 16'd1, random_table());
    run_ticks(500);
  endtask

  // Hold the result side off long enough for the block to stall its input.
  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 80; i++) send_tick($urandom_range(0, 5) != 0);
    idle_on = 1'b1;
  endtask

  // Long ramp interval with no floor: the period drops only every hundred
  // or so ticks while the ramp counter runs far past small values.
  task automatic test_slow_ramp();
    configure(WAIT_W'($urandom_range(0, 255)), 8'h00, 16'd100, random_table());
    run_ticks(400);
  endtask

  // Drive the period to zero; the wait counter overtakes it on the way and
  // every later high tick steps through all phases.
  task automatic test_zero_period();
    configure(8'h00, 8'h00, 16'h0000, random_table());
    run_ticks(650);
  endtask

  // Receiver: random stalls, or a forced hold while hold_left runs down.
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) stall_left = gap_length();
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    psr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coil_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatch_count++;
      end else begin
        want = pending_coil_results.pop_front();
        if (out_drive_n !== want.drive_n) begin
          $error("drive_n: expected %0h, got %0h", want.drive_n, out_drive_n);
          mismatch_count++;
        end
        if (out_phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_phase);
          mismatch_count++;
        end
        if (out_step_period !== want.step_period) begin
          $error("step_period: expected %0d, got %0d", want.step_period, out_step_period);
          mismatch_count++;
        end
        if (out_stepped !== want.stepped) begin
          $error("stepped: expected %0b, got %0b", want.stepped, out_stepped);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if the block stops moving.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // Hold reset at the start, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_first_tick();
    test_register_extremes();
    test_ramp_to_floor();
    test_backpressure();
    test_slow_ramp();
    test_zero_period();
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
